// ===== src/hvn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

    localparam int HVN_MAX_DIM = 256;

    // stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE   = 2'd2;

    // item kinds carried on tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // face-normal sums and the squared length
    localparam int SUM_W = 11;
    localparam int SQ_W  = 2 * SUM_W;
    localparam int Q_W   = SQ_W + 2;
    localparam int QUO_W = 33;
    localparam int ROOT_W = 16;
    localparam int DIV_STEPS  = 32;
    localparam int ROOT_STEPS = 16;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_SQUARE = 8'b0000_0100,
        S_SUM    = 8'b0000_1000,
        S_INIT   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_ROOT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

// ===== src/heightmap_vertex_normals.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s stream  in   i_s_tvalid/o_s_tready  tdata: column, grid_row, height; tuser: mode
// m stream  out  o_m_tvalid/i_m_tready  tdata: normal_x, normal_y, normal_z; tuser: error
// cfg       in   i_cfg_we               i_cfg_index, i_cfg_data
//
// A height write leaves the block in idle. A normal read makes 12 reads from
// the single-port height memory, squares and sum, a 32-step restoring divide
// and a 16-step root search (three lanes side by side). An address error read
// goes straight to the output state. Synchronous active-low reset sets control
// and configuration to defaults; the height memory is not cleared. A held result
// in the output register does not block the next transfer in; only the final load does.
module heightmap_vertex_normals
    import hvn_pkg::*;
#(
    parameter int MAX_DIM = HVN_MAX_DIM
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] column, [15:8] grid_row, [23:16] height
    input  wire                   i_s_tuser,   // [0] mode
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z
    output logic                  o_m_tuser,   // [0] address_error
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [8:0] r_grid_width, r_grid_height;
    logic       r_normalize;

    logic [9:0] w_use, h_use;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    logic [7:0] r_col, r_row;
    logic       r_err;
    logic [1:0] r_face, r_sub;
    logic       r_issue_done;
    logic       r_rd_pend, r_rd_use;
    logic [1:0] r_rd_sub;
    logic [7:0] r_h00;
    logic signed [SUM_W-1:0] r_sx, r_sz;
    logic [2:0] r_nface;
    logic [5:0] r_cnt;

    logic [2:0]        r_neg;
    logic [SQ_W-1:0]   r_sq   [3];
    logic [Q_W-1:0]    r_q;
    logic [Q_W-1:0]    r_rem  [3];
    logic [QUO_W-1:0]  r_quo  [3];
    logic [ROOT_W-1:0] r_root [3];

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_err;

    logic s_xfer, m_xfer, out_free;
    logic in_mode;
    logic [7:0] in_col, in_row, in_height;
    logic in_range;

    logic issuing, face_ok;
    logic [9:0] ax, ay, rx, ry;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [5:0] sy;
    logic [3:0] root_bit;

    assign in_mode   = i_s_tuser;
    assign in_col    = i_s_tdata[7:0];
    assign in_row    = i_s_tdata[15:8];
    assign in_height = i_s_tdata[23:16];

    // dimensions above the memory size act as the memory size
    always_comb begin
        w_use = (32'(r_grid_width) > MAX_DIM) ? 10'(MAX_DIM) : {1'b0, r_grid_width};
        h_use = (32'(r_grid_height) > MAX_DIM) ? 10'(MAX_DIM) : {1'b0, r_grid_height};
    end

    assign in_range = ({2'b0, in_col} < w_use) && ({2'b0, in_row} < h_use);
    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer = i_s_tvalid && o_s_tready;
    assign m_xfer = r_ovalid && i_m_tready;
    assign out_free = !r_ovalid || i_m_tready;

    // face (a, b) with a = col - 1 + face[0], b = row - 1 + face[1]
    always_comb begin
        face_ok = (r_face[0] || r_col != 8'd0) && (r_face[1] || r_row != 8'd0)
               && ({2'b0, r_col} + 10'd1 + {9'b0, r_face[0]} <= w_use)
               && ({2'b0, r_row} + 10'd1 + {9'b0, r_face[1]} <= h_use);
        ax = {2'b0, r_col} + {9'b0, r_face[0]} - 10'd1;
        ay = {2'b0, r_row} + {9'b0, r_face[1]} - 10'd1;
        rx = ax + ((r_sub == 2'd1) ? 10'd1 : 10'd0);
        ry = ay + ((r_sub == 2'd2) ? 10'd1 : 10'd0);
        rd_addr = ADDR_W'(32'(ry) * MAX_DIM + 32'(rx));
        wr_addr = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
        issuing = (r_state == S_READ) && !r_issue_done;
        sy = r_normalize ? 6'({r_nface, 4'b0} - {4'b0, r_nface}) : {3'b0, r_nface};
        root_bit = 4'(ROOT_STEPS - 1 - 32'(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && in_mode == MODE_WRITE && in_range) begin
            mem[wr_addr] <= in_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issuing) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer && in_mode == MODE_READ) begin
                    n_state = (in_range && w_use >= 10'd2 && h_use >= 10'd2) ? S_READ : S_OUT;
                end
            end
            S_READ:   if (r_issue_done && !r_rd_pend) n_state = S_SQUARE;
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_INIT;
            S_INIT:   n_state = S_DIV;
            S_DIV:    if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_ROOT;
            S_ROOT:   if (r_cnt == 6'(ROOT_STEPS - 1)) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_width  <= 9'd256;
            r_grid_height <= 9'd256;
            r_normalize   <= 1'b0;
            r_ovalid      <= 1'b0;
            r_rd_pend     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issuing;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                    REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                    REG_NORMALIZE:   r_normalize   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_xfer) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [SUM_W-1:0]    mag;
        logic [Q_W:0]        rem2;
        logic                ge;
        logic [ROOT_W-1:0]   cand;
        logic [ROOT_W:0]     d;
        logic [2*ROOT_W+1:0] dd;
        logic [ROOT_W-1:0]   comp [3];
        logic signed [9:0]   diff;

        r_rd_use <= issuing && face_ok;
        r_rd_sub <= r_sub;

        case (r_state)
            S_IDLE: begin
                r_col        <= in_col;
                r_row        <= in_row;
                r_err        <= !(in_range && w_use >= 10'd2 && h_use >= 10'd2);
                r_face       <= 2'd0;
                r_sub        <= 2'd0;
                r_issue_done <= 1'b0;
                r_sx         <= '0;
                r_sz         <= '0;
                r_nface      <= 3'd0;
            end
            S_READ: begin
                if (issuing) begin
                    if (r_sub == 2'd2) begin
                        r_sub  <= 2'd0;
                        r_face <= r_face + 2'd1;
                        if (r_face == 2'd3) r_issue_done <= 1'b1;
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                if (r_rd_use) begin
                    diff = $signed({2'b0, r_h00}) - $signed({2'b0, r_rd_data});
                    case (r_rd_sub)
                        2'd0: begin
                            r_h00   <= r_rd_data;
                            r_nface <= r_nface + 3'd1;
                        end
                        2'd1: r_sx <= r_sx + SUM_W'(diff);
                        2'd2: r_sz <= r_sz + SUM_W'(diff);
                        default: ;
                    endcase
                end
            end
            S_SQUARE: begin
                mag = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
                r_sq[LANE_X] <= mag * mag;
                mag = SUM_W'(sy);
                r_sq[LANE_Y] <= mag * mag;
                mag = r_sz[SUM_W-1] ? SUM_W'(-r_sz) : SUM_W'(r_sz);
                r_sq[LANE_Z] <= mag * mag;
                r_neg <= {r_sz[SUM_W-1], 1'b0, r_sx[SUM_W-1]};
            end
            S_SUM: begin
                r_q <= Q_W'(r_sq[0]) + Q_W'(r_sq[1]) + Q_W'(r_sq[2]);
            end
            S_INIT: begin
                // the magnitude never exceeds the length, so the quotient top bit is 0 or 1
                for (int i = 0; i < 3; i++) begin
                    ge = Q_W'(r_sq[i]) >= r_q;
                    r_quo[i] <= QUO_W'(ge);
                    r_rem[i] <= ge ? Q_W'(r_sq[i]) - r_q : Q_W'(r_sq[i]);
                end
                r_cnt <= 6'd0;
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_rem[i], 1'b0};
                    ge = rem2 >= {1'b0, r_q};
                    r_rem[i] <= ge ? Q_W'(rem2 - {1'b0, r_q}) : rem2[Q_W-1:0];
                    r_quo[i] <= {r_quo[i][QUO_W-2:0], ge};
                    r_root[i] <= '0;
                end
                r_cnt <= (r_cnt == 6'(DIV_STEPS - 1)) ? 6'd0 : r_cnt + 6'd1;
            end
            S_ROOT: begin
                // keep the largest m with (2m-1)^2 <= quotient
                for (int i = 0; i < 3; i++) begin
                    cand = r_root[i] | (ROOT_W'(1) << root_bit);
                    d = {cand, 1'b0} - (ROOT_W+1)'(1);
                    dd = d * d;
                    if (dd <= (2*ROOT_W+2)'(r_quo[i])) r_root[i] <= cand;
                end
                r_cnt <= r_cnt + 6'd1;
            end
            S_OUT: begin
                if (out_free) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_neg[i]) comp[i] = ROOT_W'(-r_root[i]);
                        else comp[i] = r_root[i][ROOT_W-1] ? 16'h7FFF : r_root[i];
                    end
                    if (r_err) begin
                        r_out_data <= '0;
                    end else begin
                        r_out_data <= {1'b0, comp[LANE_Z], comp[LANE_Y][14:0], comp[LANE_X]};
                    end
                    r_out_err <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("error result with nonzero normal");

    a_y_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[30:16] != 15'd0))
        else $error("valid normal with zero vertical component");

    a_face_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQUARE) |-> (r_nface != 3'd0))
        else $error("normal computed with no face");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_quo[LANE_Y] <= {1'b1, 32'd0}))
        else $error("quotient above full scale");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hvn_pkg::*;

    typedef struct {
        logic signed [15:0] nx;
        logic        [14:0] ny;
        logic signed [15:0] nz;
        logic               err;
    } normal_t;

    typedef struct {
        logic       mode;
        int         col;
        int         row;
        int         hgt;
        bit         typed;
        normal_t    res;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    heightmap_vertex_normals dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // shadow of the block: height grid, written flags, registers
    logic [7:0] hmap [0:65535];
    bit         hmap_set [0:65535];
    int         cfg_w = 256;
    int         cfg_h = 256;
    bit         cfg_norm = 1'b0;
    normal_t    pending_normals [$];
    int         errors = 0;
    int         burst_left = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int dim_eff(input int r);
        return (r > 256) ? 256 : r;
    endfunction

    function automatic int height_at(input int a, input int b);
        return hmap[(b * 256 + a) % 65536];
    endfunction

    // round(32768*s/sqrt(q)) ties away from zero, saturated
    function automatic int unit_len(input int s, input longint unsigned q);
        longint unsigned mag, t, lim, lo, hi, mid, d;
        int r;
        mag = (s < 0) ? -s : s;
        t = mag * 32768;
        lim = 4 * t * t;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 2 * mid - 1;
            if (d * d * q <= lim) lo = mid;
            else hi = mid - 1;
        end
        r = int'(lo);
        if (s < 0) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic normal_t predict_normal(input int col, input int row);
        normal_t n;
        int w, h, k, sx, sy, sz, a, b, h00, ny;
        longint unsigned q;
        w = dim_eff(cfg_w);
        h = dim_eff(cfg_h);
        k = cfg_norm ? 15 : 1;
        sx = 0;
        sy = 0;
        sz = 0;
        n = '{nx: '0, ny: '0, nz: '0, err: 1'b1};
        if (w < 2 || h < 2 || col >= w || row >= h) return n;
        for (int db = -1; db <= 0; db++) begin
            for (int da = -1; da <= 0; da++) begin
                a = col + da;
                b = row + db;
                if (a < 0 || b < 0 || a > w - 2 || b > h - 2) continue;
                h00 = height_at(a, b);
                sx += h00 - height_at(a + 1, b);
                sy += k;
                sz += h00 - height_at(a, b + 1);
            end
        end
        q = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
        ny = unit_len(sy, q);
        if (ny < 0) ny = 0;
        n.nx = 16'(unit_len(sx, q));
        n.ny = 15'(ny);
        n.nz = 16'(unit_len(sz, q));
        n.err = 1'b0;
        return n;
    endfunction

    task automatic send_item(input logic mode, input int col, input int row, input int hgt,
                             input bit typed = 0, input normal_t res = '{0, 0, 0, 0});
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 10) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = mode;
        i_s_tdata  = {8'(hgt), 8'(row), 8'(col)};
        do @(posedge i_clk); while (!o_s_tready);
        if (mode == MODE_WRITE) begin
            if (col < dim_eff(cfg_w) && row < dim_eff(cfg_h)) begin
                hmap[row * 256 + col] = 8'(hgt);
                hmap_set[row * 256 + col] = 1'b1;
            end
        end else begin
            pending_normals.push_back(typed ? res : predict_normal(col, row));
        end
    endtask

    function automatic int rand_height();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // write every cell a read at (col,row) uses that is still blank
    task automatic fill_around(input int col, input int row);
        int w, h, a, b;
        w = dim_eff(cfg_w);
        h = dim_eff(cfg_h);
        if (w < 2 || h < 2 || col >= w || row >= h) return;
        for (int db = -1; db <= 0; db++) begin
            for (int da = -1; da <= 0; da++) begin
                a = col + da;
                b = row + db;
                if (a < 0 || b < 0 || a > w - 2 || b > h - 2) continue;
                if (!hmap_set[b * 256 + a]) send_item(MODE_WRITE, a, b, rand_height());
                if (!hmap_set[b * 256 + a + 1]) send_item(MODE_WRITE, a + 1, b, rand_height());
                if (!hmap_set[(b + 1) * 256 + a])
                    send_item(MODE_WRITE, a, b + 1, rand_height());
            end
        end
    endtask

    // hold the sender until every result is back, then let the datapath settle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_W'(val);
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_GRID_WIDTH) cfg_w = val & 9'h1FF;
        else if (idx == REG_GRID_HEIGHT) cfg_h = val & 9'h1FF;
        else if (idx == REG_NORMALIZE) cfg_norm = val & 1;
    endtask

    task automatic set_grid(input int w, input int h, input int nrm);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_NORMALIZE, nrm);
    endtask

    task automatic random_phase(input int n_items);
        int w, h, c, r;
        w = dim_eff(cfg_w);
        h = dim_eff(cfg_h);
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 9))
                0: send_item(MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
                1: begin
                    c = $urandom_range(0, 255);
                    r = $urandom_range(0, 255);
                    fill_around(c, r);
                    send_item(MODE_READ, c, r, $urandom_range(0, 255));
                end
                default: begin
                    c = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? w - 1 : 0)
                                                    : $urandom_range(0, (w > 0) ? w - 1 : 0);
                    r = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? h - 1 : 0)
                                                    : $urandom_range(0, (h > 0) ? h - 1 : 0);
                    if ($urandom_range(0, 2) == 0)
                        send_item(MODE_WRITE, c, r, rand_height());
                    fill_around(c, r);
                    send_item(MODE_READ, c, r, $urandom_range(0, 255));
                end
            endcase
        end
    endtask

    // receiver backpressure: switch between stall patterns now and then
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt  = $urandom_range(20, 200);
        end
        stall_cnt--;
        case (stall_mode)
            0: i_m_tready = 1'b1;
            1: i_m_tready = ($urandom_range(0, 3) != 0);
            2: i_m_tready = ($urandom_range(0, 3) == 0);
            default: i_m_tready = (stall_cnt % 16) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        normal_t e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_normals.size() == 0) begin
                report("result transfer with nothing outstanding");
            end else begin
                e = pending_normals.pop_front();
                if ($signed(o_m_tdata[15:0]) != e.nx)
                    report($sformatf("normal_x %0d, want %0d",
                                     $signed(o_m_tdata[15:0]), e.nx));
                if (o_m_tdata[30:16] != e.ny)
                    report($sformatf("normal_y %0d, want %0d", o_m_tdata[30:16], e.ny));
                if ($signed(o_m_tdata[46:31]) != e.nz)
                    report($sformatf("normal_z %0d, want %0d",
                                     $signed(o_m_tdata[46:31]), e.nz));
                if (o_m_tuser != e.err)
                    report($sformatf("address_error %0b, want %0b", o_m_tuser, e.err));
            end
        end
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    localparam normal_t FLAT = '{nx: 16'sd0, ny: 15'd32767, nz: 16'sd0, err: 1'b0};
    localparam normal_t ADDR_ERR = '{nx: 16'sd0, ny: 15'd0, nz: 16'sd0, err: 1'b1};

    dir_row_t directed [] = '{
        '{MODE_WRITE, 0, 0, 0, 0, ADDR_ERR}, '{MODE_WRITE, 1, 0, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 2, 0, 0, 0, ADDR_ERR}, '{MODE_WRITE, 0, 1, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 1, 1, 0, 0, ADDR_ERR}, '{MODE_WRITE, 2, 1, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 0, 2, 0, 0, ADDR_ERR}, '{MODE_WRITE, 1, 2, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 2, 2, 0, 0, ADDR_ERR},
        // flat grid: straight up, vertical saturates
        '{MODE_READ, 1, 1, 0, 1, FLAT},
        '{MODE_READ, 2, 2, 255, 1, FLAT},
        // out-of-range write is dropped, out-of-range reads flag
        '{MODE_WRITE, 255, 255, 170, 0, ADDR_ERR},
        '{MODE_READ, 3, 0, 0, 1, ADDR_ERR},
        '{MODE_READ, 255, 255, 0, 1, ADDR_ERR},
        '{MODE_READ, 0, 3, 0, 1, ADDR_ERR},
        '{MODE_WRITE, 0, 0, 255, 0, ADDR_ERR},
        '{MODE_READ, 0, 0, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 2, 1, 255, 0, ADDR_ERR},
        '{MODE_READ, 1, 1, 0, 0, ADDR_ERR},
        '{MODE_READ, 2, 1, 0, 0, ADDR_ERR},
        '{MODE_WRITE, 1, 2, 85, 0, ADDR_ERR},
        '{MODE_READ, 1, 2, 0, 0, ADDR_ERR}
    };

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_grid(3, 3, 0);
        foreach (directed[i])
            send_item(directed[i].mode, directed[i].col, directed[i].row, directed[i].hgt,
                      directed[i].typed, directed[i].res);
        drain();
        write_reg(REG_NORMALIZE, 1);
        send_item(MODE_READ, 1, 1, 0);
        send_item(MODE_READ, 0, 0, 0);
        drain();

        // degenerate grid: every read flags
        set_grid(1, 4, 0);
        random_phase(30);
        drain();

        // large grids pull in several fill writes per read
        set_grid(256, 256, 0); random_phase(15); drain();
        set_grid(2, 2, 1);     random_phase(40); drain();
        set_grid(2, 256, 0);   random_phase(12); drain();
        set_grid(256, 2, 1);   random_phase(12); drain();
        set_grid(511, 300, 1); random_phase(10); drain();
        set_grid(7, 5, 0);     random_phase(50); drain();
        set_grid(16, 16, 1);   random_phase(25); drain();
        set_grid($urandom_range(2, 256), $urandom_range(2, 256), $urandom_range(0, 1));
        random_phase(15);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hvn_pkg.sv
src/heightmap_vertex_normals.sv
dv/tb_top.sv
